[rtl/mqw_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mqw_pkg
// Shared types and constants of the message queue with waiter lists.
// ----------------------------------------------------------------------------
package mqw_pkg;

    localparam int DEF_RING_SLOTS = 16;
    localparam int DEF_TASK_SLOTS = 8;
    localparam int DEF_ITEM_BITS  = 32;

    localparam int DEPTH_W = 5;
    localparam int TASK_W  = 3;
    localparam int DATA_W  = 32;
    localparam int MASK_W  = 8;

    localparam logic [DEPTH_W-1:0] RESET_DEPTH = 5'd16;

    typedef enum logic [1:0] {
        MODE_PUT_BLK  = 2'd0,
        MODE_TAKE_BLK = 2'd1,
        MODE_PUT_ISR  = 2'd2,
        MODE_TAKE_ISR = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_REJECT  = 2'd1,
        ST_BLOCKED = 2'd2,
        ST_FAULT   = 2'd3
    } t_status;

    typedef struct packed {
        logic push;
        logic pop;
    } t_ring_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_ring_sts;

    typedef struct packed {
        logic              record;
        logic              wake;
        logic [TASK_W-1:0] task_id;
    } t_wait_cmd;

endpackage
`default_nettype wire

[rtl/mqw_ring.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mqw_ring
// Ring buffer store with head/tail indices, fill count and depth register.
// The read port prefetches the item at the next read index every cycle.
// ----------------------------------------------------------------------------
module mqw_ring #(
    parameter int RING_SLOTS = mqw_pkg::DEF_RING_SLOTS,
    parameter int ITEM_BITS  = mqw_pkg::DEF_ITEM_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [mqw_pkg::DEPTH_W-1:0] i_cfg_depth,
    input  wire mqw_pkg::t_ring_cmd          i_cmd,
    input  wire logic [ITEM_BITS-1:0]        i_wr_data,
    output mqw_pkg::t_ring_sts               o_sts,
    output logic [ITEM_BITS-1:0]             o_rd_data
);

    localparam int IDX_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int CNT_W = $clog2(RING_SLOTS + 1);
    localparam int CMP_W = (CNT_W > mqw_pkg::DEPTH_W) ? CNT_W : mqw_pkg::DEPTH_W;

    logic [ITEM_BITS-1:0] mem [RING_SLOTS];

    logic [mqw_pkg::DEPTH_W-1:0] r_depth;
    logic [IDX_W-1:0]            r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0]            r_wr_idx, n_wr_idx;
    logic [CNT_W-1:0]            r_fill,   n_fill;
    logic [ITEM_BITS-1:0]        r_rd_data;

    logic [CMP_W-1:0] eff_depth;
    logic [CMP_W-1:0] rd_inc, wr_inc;

    always_comb begin
        // zero acts as one, anything above the ring size as the ring size
        if (r_depth == '0) begin
            eff_depth = CMP_W'(1);
        end else if (CMP_W'(r_depth) > CMP_W'(RING_SLOTS)) begin
            eff_depth = CMP_W'(RING_SLOTS);
        end else begin
            eff_depth = CMP_W'(r_depth);
        end
    end

    assign o_sts.full  = (CMP_W'(r_fill) >= eff_depth);
    assign o_sts.empty = (r_fill == '0);

    assign rd_inc = CMP_W'(r_rd_idx) + CMP_W'(1);
    assign wr_inc = CMP_W'(r_wr_idx) + CMP_W'(1);

    always_comb begin
        n_rd_idx = r_rd_idx;
        n_wr_idx = r_wr_idx;
        n_fill   = r_fill;
        if (i_cmd.push) begin
            n_wr_idx = (wr_inc >= eff_depth) ? '0 : IDX_W'(wr_inc);
            n_fill   = r_fill + CNT_W'(1);
        end else if (i_cmd.pop) begin
            n_rd_idx = (rd_inc >= eff_depth) ? '0 : IDX_W'(rd_inc);
            n_fill   = r_fill - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= mqw_pkg::RESET_DEPTH;
            r_rd_idx <= '0;
            r_wr_idx <= '0;
            r_fill   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_depth <= i_cfg_depth;
            end
            r_rd_idx <= n_rd_idx;
            r_wr_idx <= n_wr_idx;
            r_fill   <= n_fill;
        end
    end

    // store and prefetch; a write to the slot being fetched forwards its beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_wr_idx] <= i_wr_data;
        end
        if (i_cmd.push && (r_wr_idx == n_rd_idx)) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= mem[n_rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_fill) <= CMP_W'(RING_SLOTS))
        else $error("fill count above ring size");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> !o_sts.full)
        else $error("push into full ring");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (!o_sts.empty && !i_cmd.push))
        else $error("pop from empty ring or with push");
`endif

endmodule
`default_nettype wire

[rtl/mqw_waiters.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mqw_waiters
// Table of blocked tasks: records a task in the first free slot, or wakes
// and clears every recorded task at once.
// ----------------------------------------------------------------------------
module mqw_waiters #(
    parameter int TASK_SLOTS = mqw_pkg::DEF_TASK_SLOTS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire mqw_pkg::t_wait_cmd         i_cmd,
    output logic                            o_none_free,
    output logic [mqw_pkg::MASK_W-1:0]      o_wake_mask
);

    logic [TASK_SLOTS-1:0]        r_vld;
    logic [mqw_pkg::TASK_W-1:0]   r_task [TASK_SLOTS];
    logic [TASK_SLOTS-1:0]        free_sel;
    logic                         found;

    // first free slot
    always_comb begin
        free_sel = '0;
        found    = 1'b0;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            if (!r_vld[i] && !found) begin
                free_sel[i] = 1'b1;
                found       = 1'b1;
            end
        end
    end

    assign o_none_free = &r_vld;

    always_comb begin
        o_wake_mask = '0;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            if (r_vld[i]) begin
                o_wake_mask[r_task[i]] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.wake) begin
            r_vld <= '0;
        end else if (i_cmd.record) begin
            r_vld <= r_vld | free_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TASK_SLOTS; i++) begin
            if (i_cmd.record && free_sel[i]) begin
                r_task[i] <= i_cmd.task_id;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(free_sel) && ((free_sel == '0) == o_none_free))
        else $error("free slot select malformed");

    a_record_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.record && !i_cmd.wake && !o_none_free)
            |=> ($countones(r_vld) == $countones($past(r_vld)) + 1))
        else $error("record did not take exactly one slot");

    a_wake_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wake |=> (r_vld == '0))
        else $error("wake left waiters behind");
`endif

endmodule
`default_nettype wire

[rtl/message_queue_with_waiter_lists.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// message_queue_with_waiter_lists
// RTOS message queue: ring buffer plus put and take waiter tables.
// ----------------------------------------------------------------------------
// One access per clock: an access is taken on start while busy is low and its
// result appears with o_done after the input register and one pass of ring and
// waiter-table logic into the result register. Busy is high only in the cycle
// after reset, so back-to-back accesses run at one per cycle. Results come for
// one cycle only and cannot be held off. The queue depth write channel is
// always ready; write it only while no access is in flight.
// ----------------------------------------------------------------------------
module message_queue_with_waiter_lists #(
    parameter int RING_SLOTS = mqw_pkg::DEF_RING_SLOTS,
    parameter int TASK_SLOTS = mqw_pkg::DEF_TASK_SLOTS,
    parameter int ITEM_BITS  = mqw_pkg::DEF_ITEM_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  i_mode,
    input  wire logic [mqw_pkg::TASK_W-1:0]  i_task_id,
    input  wire logic [mqw_pkg::DATA_W-1:0]  i_put_data,
    output logic                             o_done,
    output logic [1:0]                       o_status,
    output logic [mqw_pkg::DATA_W-1:0]       o_take_data,
    output logic [mqw_pkg::MASK_W-1:0]       o_wake_mask,
    output logic                             o_switch_request,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [mqw_pkg::DEPTH_W-1:0] i_cfg_data
);

    // input register
    logic                        r_busy;
    logic                        r_in_vld;
    mqw_pkg::t_mode              r_mode;
    logic [mqw_pkg::TASK_W-1:0]  r_task;
    logic [mqw_pkg::DATA_W-1:0]  r_data;

    // result register
    logic                        r_out_vld;
    mqw_pkg::t_status            r_status, n_status;
    logic [mqw_pkg::DATA_W-1:0]  r_take_data, n_take_data;
    logic [mqw_pkg::MASK_W-1:0]  r_wake_mask, n_wake_mask;
    logic                        r_switch, n_switch;

    logic                        is_put, is_isr, blocked, success;
    mqw_pkg::t_ring_cmd          ring_cmd;
    mqw_pkg::t_ring_sts          ring_sts;
    logic [ITEM_BITS-1:0]        ring_rd_data;
    mqw_pkg::t_wait_cmd          put_wcmd, take_wcmd;
    logic                        put_none_free, take_none_free;
    logic [mqw_pkg::MASK_W-1:0]  put_wake, take_wake;

    logic in_accept;
    assign in_accept   = start && !r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_busy    <= 1'b0;
            r_in_vld  <= in_accept;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode <= mqw_pkg::t_mode'(i_mode);
            r_task <= i_task_id;
            r_data <= i_put_data;
        end
    end

    always_comb begin
        unique case (r_mode)
            mqw_pkg::MODE_PUT_BLK:  begin is_put = 1'b1; is_isr = 1'b0; end
            mqw_pkg::MODE_TAKE_BLK: begin is_put = 1'b0; is_isr = 1'b0; end
            mqw_pkg::MODE_PUT_ISR:  begin is_put = 1'b1; is_isr = 1'b1; end
            mqw_pkg::MODE_TAKE_ISR: begin is_put = 1'b0; is_isr = 1'b1; end
            default:                begin is_put = 1'b0; is_isr = 1'b0; end
        endcase
    end

    assign blocked = is_put ? ring_sts.full : ring_sts.empty;
    assign success = r_in_vld && !blocked;

    assign ring_cmd.push = success && is_put;
    assign ring_cmd.pop  = success && !is_put;

    // a blocking put waits on full, a blocking take on empty; a good access wakes the other side
    assign put_wcmd.record  = r_in_vld && is_put && blocked && !is_isr;
    assign put_wcmd.wake    = ring_cmd.pop;
    assign put_wcmd.task_id = r_task;

    assign take_wcmd.record  = r_in_vld && !is_put && blocked && !is_isr;
    assign take_wcmd.wake    = ring_cmd.push;
    assign take_wcmd.task_id = r_task;

    mqw_ring #(
        .RING_SLOTS (RING_SLOTS),
        .ITEM_BITS  (ITEM_BITS)
    ) u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_depth (i_cfg_data),
        .i_cmd       (ring_cmd),
        .i_wr_data   (ITEM_BITS'(r_data)),
        .o_sts       (ring_sts),
        .o_rd_data   (ring_rd_data)
    );

    mqw_waiters #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_put_waiters (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (put_wcmd),
        .o_none_free (put_none_free),
        .o_wake_mask (put_wake)
    );

    mqw_waiters #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_take_waiters (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (take_wcmd),
        .o_none_free (take_none_free),
        .o_wake_mask (take_wake)
    );

    always_comb begin
        n_take_data = '0;
        n_wake_mask = '0;
        priority if (!blocked) begin
            n_status = mqw_pkg::ST_DONE;
            if (is_put) begin
                n_wake_mask = take_wake;
            end else begin
                n_wake_mask = put_wake;
                n_take_data = mqw_pkg::DATA_W'(ring_rd_data);
            end
        end else if (is_isr) begin
            n_status = mqw_pkg::ST_REJECT;
        end else if (is_put ? put_none_free : take_none_free) begin
            n_status = mqw_pkg::ST_FAULT;
        end else begin
            n_status = mqw_pkg::ST_BLOCKED;
        end
        n_switch = (n_status == mqw_pkg::ST_BLOCKED) || (n_wake_mask != '0);
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_status    <= n_status;
            r_take_data <= n_take_data;
            r_wake_mask <= n_wake_mask;
            r_switch    <= n_switch;
        end
    end

    assign o_done           = r_out_vld;
    assign o_status         = r_status;
    assign o_take_data      = r_take_data;
    assign o_wake_mask      = r_wake_mask;
    assign o_switch_request = r_switch;

`ifndef NO_ASSERTIONS
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |-> ##2 o_done)
        else $error("accepted beat produced no result");

    a_wake_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ((o_wake_mask != '0) || (o_take_data != '0)))
            |-> (o_status == mqw_pkg::ST_DONE))
        else $error("wake or data on a failed access");

    a_switch_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_switch_request ==
            ((o_status == mqw_pkg::ST_BLOCKED) || (o_wake_mask != '0))))
        else $error("switch request mismatch");

    a_no_dual_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(put_wcmd.wake && take_wcmd.wake) && !(put_wcmd.record && take_wcmd.record))
        else $error("both waiter tables driven at once");
`endif

endmodule
`default_nettype wire
